@@ src/ttrd_pkg.sv @@
// Shared types and constants for the temperature to RGB duty unit.
// Depends on nothing; imported by temperature_to_rgb_duty_unit.
package ttrd_pkg;

    // Default converter width.
    localparam int ADC_BITS_DEF = 10;

    // Field widths.
    localparam int TEMP_W  = 16;
    localparam int DUTY_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // Temperature full scale in centidegrees.
    localparam int TEMP_FULL_SCALE = 50000;

    // Single-colour scale: duty = (MONO_GAIN * t - MONO_OFFSET) / 1000, clamped.
    localparam int MONO_GAIN   = 102;
    localparam int MONO_OFFSET = 255000;
    localparam int MONO_CLAMP  = 511000;   // offset + 256 * 1000
    localparam int MONO_P_W    = 23;       // 102 * 50000 fits
    localparam int MONO_V_W    = 18;       // below 256000 when not clamped

    // x / 1000 = (x / 8) / 125; x / 125 by reciprocal.
    localparam int DIV125_MUL   = 33555;
    localparam int DIV125_SHIFT = 22;

    // x / 440 = (x / 8) / 55; x / 55 by reciprocal.
    localparam int DIV55_MUL   = 19066;
    localparam int DIV55_SHIFT = 20;

    // Polychrome segment bounds in centidegrees.
    localparam int POLY_T0 = 2800;
    localparam int POLY_T1 = 3240;
    localparam int POLY_T2 = 3680;
    localparam int POLY_T3 = 4120;
    localparam int POLY_T4 = 4560;
    localparam int POLY_T5 = 5000;

    // Colour levels.
    localparam logic [DUTY_W-1:0] DUTY_OFF    = 8'd0;
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_VIOLET = 8'd180;
    localparam logic [DUTY_W-1:0] DUTY_HALF   = 8'd128;
    localparam logic [DUTY_W-1:0] SLOPE_GREEN_HI = 8'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_MODE   = 2'd0,
        CFG_SCALE_SELECT = 2'd1,
        CFG_TOUCH_COLOUR = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SCALE_BLUE  = 2'd0,
        SCALE_RED   = 2'd1,
        SCALE_GREEN = 2'd2,
        SCALE_POLY  = 2'd3
    } t_scale;

    typedef enum logic [2:0] {
        TOUCH_BLUE   = 3'd0,
        TOUCH_RED    = 3'd1,
        TOUCH_GREEN  = 3'd2,
        TOUCH_WHITE  = 3'd3,
        TOUCH_VIOLET = 3'd4,
        TOUCH_YELLOW = 3'd5
    } t_touch;

    // Polychrome segment, coldest first.
    typedef enum logic [2:0] {
        SEG_COLD    = 3'd0,
        SEG_VIO_BLU = 3'd1,
        SEG_BLU_GRN = 3'd2,
        SEG_GRN_YEL = 3'd3,
        SEG_YEL_ORG = 3'd4,
        SEG_ORG_RED = 3'd5,
        SEG_HOT     = 3'd6
    } t_seg;

endpackage

@@ src/temperature_to_rgb_duty_unit.sv @@
// Temperature to RGB duty unit: ADC sample to centidegrees and LED duties.
// Depends on ttrd_pkg (constants, register and colour codes).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | to unit   | i_in_valid / o_in_ready    | i_adc_sample
//  out     | from unit | o_out_valid / i_out_ready  | o_temp_centi, o_*_duty
//  cfg     | to unit   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  A request passes five register stages: scale multiply, modulus fold,
//  temperature, segment and product, and the output register. A new request
//  is taken every cycle while the output drains.
//  Reset (synchronous, active low) clears the stage valid bits and the
//  configuration registers. A stall on the output holds each full stage; an
//  empty stage keeps taking data, so bubbles are squeezed out and nothing is
//  dropped or repeated. Configuration writes are always taken.
module temperature_to_rgb_duty_unit
    import ttrd_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ADC_BITS-1:0]   i_adc_sample,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TEMP_W-1:0]     o_temp_centi,
    output logic [DUTY_W-1:0]     o_red_duty,
    output logic [DUTY_W-1:0]     o_green_duty,
    output logic [DUTY_W-1:0]     o_blue_duty,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Scaled sample width and fold width.
    localparam int XW = ADC_BITS + TEMP_W;
    localparam int ZW = TEMP_W + 1;
    localparam logic [ZW-1:0] FULL = ZW'((1 << ADC_BITS) - 1);

    localparam int VW   = 17;          // 255 * 440 fits
    localparam int QW   = VW - 3 + 15; // (v / 8) * DIV55_MUL
    localparam int MQW  = MONO_V_W - 3 + 16;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic   r_drive_mode;
    t_scale r_scale_select;
    t_touch r_touch_colour;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode   <= 1'b0;
            r_scale_select <= SCALE_BLUE;
            r_touch_colour <= TOUCH_BLUE;
        end else if (i_cfg_valid) begin
            // unknown index: drop the write
            unique case (i_cfg_index)
                CFG_DRIVE_MODE:   r_drive_mode   <= i_cfg_data[0];
                CFG_SCALE_SELECT: r_scale_select <= t_scale'(i_cfg_data[1:0]);
                CFG_TOUCH_COLOUR: r_touch_colour <= t_touch'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage control: a stage loads when empty or when the next one loads
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld5;

    assign w_ld5 = !r_v5 || i_out_ready;
    assign w_ld4 = !r_v4 || w_ld5;
    assign w_ld3 = !r_v3 || w_ld4;
    assign w_ld2 = !r_v2 || w_ld3;
    assign w_ld1 = !r_v1 || w_ld2;

    assign o_in_ready  = w_ld1;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_ld1) r_v1 <= i_in_valid;
            if (w_ld2) r_v2 <= r_v1;
            if (w_ld3) r_v3 <= r_v2;
            if (w_ld4) r_v4 <= r_v3;
            if (w_ld5) r_v5 <= r_v4;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: scale the sample by the full-scale temperature
    // ---------------------------------------------------------------
    logic [XW-1:0] r_x1, n_x1;

    assign n_x1 = XW'(i_adc_sample) * XW'(TEMP_FULL_SCALE);

    // ---------------------------------------------------------------
    // Stage 2: divide by 2^N - 1 by folding. With x = y * 2^N + r,
    // x / (2^N - 1) = y + (y + r) / (2^N - 1). Three folds leave a
    // remainder below twice the divisor for every N in range.
    // ---------------------------------------------------------------
    logic [TEMP_W-1:0] w_y1;
    logic [ZW-1:0]     w_z1, w_y2, w_z2, w_y3, w_z3;
    logic [TEMP_W-1:0] r_ysum2, n_ysum2;
    logic [ZW-1:0]     r_z2, n_z2;

    always_comb begin
        w_y1 = r_x1[XW-1:ADC_BITS];
        w_z1 = ZW'(w_y1) + ZW'(r_x1[ADC_BITS-1:0]);
        w_y2 = w_z1 >> ADC_BITS;
        w_z2 = w_y2 + ZW'(w_z1[ADC_BITS-1:0]);
        w_y3 = w_z2 >> ADC_BITS;
        w_z3 = w_y3 + ZW'(w_z2[ADC_BITS-1:0]);
        n_ysum2 = w_y1 + TEMP_W'(w_y2) + TEMP_W'(w_y3);
        n_z2    = w_z3;
    end

    // ---------------------------------------------------------------
    // Stage 3: final correction gives the temperature
    // ---------------------------------------------------------------
    logic [TEMP_W-1:0] r_t3, n_t3;

    assign n_t3 = r_ysum2 + TEMP_W'(r_z2 >= FULL);

    // ---------------------------------------------------------------
    // Stage 4: pick the polychrome segment, form the two lane products
    // and the single-colour product
    // ---------------------------------------------------------------
    t_seg              n_seg4, r_seg4;
    logic [TEMP_W-1:0] w_da, w_db;
    logic [7:0]        w_ca, w_cb;
    logic [VW-1:0]     n_va4, n_vb4, r_va4, r_vb4;
    logic [MONO_P_W-1:0] w_pm, w_vm;
    logic              n_under4, n_over4, r_under4, r_over4;
    logic [MONO_V_W-4:0] n_vm4, r_vm4;
    logic [TEMP_W-1:0] r_t4;

    always_comb begin
        w_da = '0;
        w_db = '0;
        w_ca = DUTY_OFF;
        w_cb = DUTY_OFF;
        if (r_t3 <= TEMP_W'(POLY_T0)) begin
            n_seg4 = SEG_COLD;
        end else if (r_t3 <= TEMP_W'(POLY_T1)) begin
            n_seg4 = SEG_VIO_BLU;
            w_da   = TEMP_W'(POLY_T1) - r_t3;
            w_ca   = DUTY_VIOLET;
        end else if (r_t3 <= TEMP_W'(POLY_T2)) begin
            n_seg4 = SEG_BLU_GRN;
            w_da   = r_t3 - TEMP_W'(POLY_T1);
            w_ca   = DUTY_FULL;
            w_db   = TEMP_W'(POLY_T2) - r_t3;
            w_cb   = DUTY_FULL;
        end else if (r_t3 <= TEMP_W'(POLY_T3)) begin
            n_seg4 = SEG_GRN_YEL;
            w_da   = r_t3 - TEMP_W'(POLY_T2);
            w_ca   = DUTY_FULL;
        end else if (r_t3 <= TEMP_W'(POLY_T4)) begin
            n_seg4 = SEG_YEL_ORG;
            w_da   = TEMP_W'(POLY_T4) - r_t3;
            w_ca   = SLOPE_GREEN_HI;
        end else if (r_t3 < TEMP_W'(POLY_T5)) begin
            n_seg4 = SEG_ORG_RED;
            w_da   = TEMP_W'(POLY_T5) - r_t3;
            w_ca   = DUTY_HALF;
        end else begin
            n_seg4 = SEG_HOT;
        end
        // offsets stay within one 440-centidegree segment
        n_va4 = VW'(w_ca) * VW'(w_da[8:0]);
        n_vb4 = VW'(w_cb) * VW'(w_db[8:0]);

        w_pm     = MONO_P_W'(r_t3) * MONO_P_W'(MONO_GAIN);
        n_under4 = w_pm < MONO_P_W'(MONO_OFFSET);
        n_over4  = w_pm >= MONO_P_W'(MONO_CLAMP);
        w_vm     = w_pm - MONO_P_W'(MONO_OFFSET);
        n_vm4    = w_vm[MONO_V_W-1:3];
    end

    // ---------------------------------------------------------------
    // Stage 5: reciprocal divides, colour selection, output register
    // ---------------------------------------------------------------
    logic [QW-1:0]      w_pa, w_pb;
    logic [MQW-1:0]     w_pmq;
    logic [DUTY_W-1:0]  w_qa, w_qb, w_mono;
    logic [DUTY_W-1:0]  n_red5, n_green5, n_blue5;
    logic [DUTY_W-1:0]  r_red5, r_green5, r_blue5;
    logic [TEMP_W-1:0]  r_t5;

    always_comb begin
        w_pa  = QW'(r_va4[VW-1:3]) * QW'(DIV55_MUL);
        w_pb  = QW'(r_vb4[VW-1:3]) * QW'(DIV55_MUL);
        w_qa  = w_pa[DIV55_SHIFT +: DUTY_W];
        w_qb  = w_pb[DIV55_SHIFT +: DUTY_W];
        w_pmq = MQW'(r_vm4) * MQW'(DIV125_MUL);
        if (r_under4) begin
            w_mono = DUTY_OFF;
        end else if (r_over4) begin
            w_mono = DUTY_FULL;
        end else begin
            w_mono = w_pmq[DIV125_SHIFT +: DUTY_W];
        end

        n_red5   = DUTY_OFF;
        n_green5 = DUTY_OFF;
        n_blue5  = DUTY_OFF;
        if (r_drive_mode) begin
            // unused touch codes leave the LED dark
            unique case (r_touch_colour)
                TOUCH_BLUE:   n_blue5 = DUTY_FULL;
                TOUCH_RED:    n_red5  = DUTY_FULL;
                TOUCH_GREEN:  n_green5 = DUTY_FULL;
                TOUCH_WHITE: begin
                    n_red5   = DUTY_FULL;
                    n_green5 = DUTY_FULL;
                    n_blue5  = DUTY_FULL;
                end
                TOUCH_VIOLET: begin
                    n_red5  = DUTY_VIOLET;
                    n_blue5 = DUTY_FULL;
                end
                TOUCH_YELLOW: begin
                    n_red5   = DUTY_FULL;
                    n_green5 = DUTY_FULL;
                end
                default: ;
            endcase
        end else begin
            unique case (r_scale_select)
                SCALE_BLUE:  n_blue5  = w_mono;
                SCALE_RED:   n_red5   = w_mono;
                SCALE_GREEN: n_green5 = w_mono;
                default: begin
                    unique case (r_seg4)
                        SEG_COLD: begin
                            n_red5  = DUTY_VIOLET;
                            n_blue5 = DUTY_FULL;
                        end
                        SEG_VIO_BLU: begin
                            n_red5  = w_qa;
                            n_blue5 = DUTY_FULL;
                        end
                        SEG_BLU_GRN: begin
                            n_green5 = w_qa;
                            n_blue5  = w_qb;
                        end
                        SEG_GRN_YEL: begin
                            n_red5   = w_qa;
                            n_green5 = DUTY_FULL;
                        end
                        SEG_YEL_ORG: begin
                            n_red5   = DUTY_FULL;
                            n_green5 = DUTY_HALF + w_qa;
                        end
                        SEG_ORG_RED: begin
                            n_red5   = DUTY_FULL;
                            n_green5 = w_qa;
                        end
                        default: n_red5 = DUTY_FULL;
                    endcase
                end
            endcase
        end
    end

    // Payload registers: advance with their stage, hold on a stall
    always_ff @(posedge i_clk) begin
        if (w_ld1) r_x1 <= n_x1;
        if (w_ld2) begin
            r_ysum2 <= n_ysum2;
            r_z2    <= n_z2;
        end
        if (w_ld3) r_t3 <= n_t3;
        if (w_ld4) begin
            r_seg4   <= n_seg4;
            r_va4    <= n_va4;
            r_vb4    <= n_vb4;
            r_vm4    <= n_vm4;
            r_under4 <= n_under4;
            r_over4  <= n_over4;
            r_t4     <= r_t3;
        end
        if (w_ld5) begin
            r_t5     <= r_t4;
            r_red5   <= n_red5;
            r_green5 <= n_green5;
            r_blue5  <= n_blue5;
        end
    end

    assign o_temp_centi = r_t5;
    assign o_red_duty   = r_red5;
    assign o_green_duty = r_green5;
    assign o_blue_duty  = r_blue5;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // The fold must leave a remainder below twice the divisor.
    a_fold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_z2 < (FULL << 1)))
        else $error("fold remainder out of range");

    // A full stage that cannot advance keeps its request.
    a_stage4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !w_ld5) |=> (r_v4 && $stable(r_t4)))
        else $error("stage 4 request lost on stall");

    // Input is refused only when every stage is occupied.
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input refused with a free stage");

    // Temperature never exceeds full scale.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_t3 <= TEMP_W'(TEMP_FULL_SCALE)))
        else $error("temperature above full scale");

endmodule
